### sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rgig_pkg.sv
// Types, constants and codes of the radial gradient index generator.
// No dependencies.
package rgig_pkg;

    localparam int SQRT_TABLE_BITS = 11;
    localparam int CACHE_BITS      = 8;
    localparam int ROM_DEPTH       = 1 << SQRT_TABLE_BITS;
    localparam int ROM_AW          = SQRT_TABLE_BITS;
    localparam int CLAMP_SHIFT     = 14 + 16 - SQRT_TABLE_BITS;
    localparam int FILL_SHIFT      = 16 - SQRT_TABLE_BITS;
    localparam int SQRT_STEPS      = 24;
    localparam int QUEUE_DEPTH     = 2;
    localparam logic [31:0] PIN_LIMIT = 32'h0000_7FFF;

    typedef enum logic [1:0] {
        TILE_CLAMP  = 2'd0,
        TILE_REPEAT = 2'd1,
        TILE_MIRROR = 2'd2,
        TILE_RSVD   = 2'd3
    } tile_mode_t;

    typedef enum logic [1:0] {
        CFG_TILE_MODE = 2'd0,
        CFG_STEP_X    = 2'd1,
        CFG_STEP_Y    = 2'd2,
        CFG_NONE      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic               new_span;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic               dither_phase;
    } in_item_t;

    typedef struct packed {
        logic [7:0] color_index;
        logic       dither_row;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               dither;
        logic               clamp;
        logic               mirror;
    } q_entry_t;

    typedef enum logic [3:0] {
        BK_FILL,
        BK_IDLE,
        BK_MUL_X,
        BK_MUL_Y,
        BK_SUM,
        BK_ROM_RD,
        BK_ROM_WAIT,
        BK_SQRT,
        BK_DONE
    } back_state_t;

endpackage

### sv/rgig_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/rgig_front.sv
// Front end: configuration registers, position accumulator, queue push.
// Depends on rgig_pkg.
module rgig_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rgig_pkg::in_item_t s_data,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              q_full,
    input  logic              fill_done,
    output logic              push,
    output rgig_pkg::q_entry_t push_entry
);
    import rgig_pkg::*;

    tile_mode_t         tile_mode_reg;
    logic signed [31:0] step_x_reg, step_y_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;
    logic               dither_reg, dither_next;
    logic               clamp;
    logic signed [31:0] inc_x, inc_y;

    assign s_ready = fill_done && !q_full;
    assign push    = s_valid && s_ready;
    assign clamp   = (tile_mode_reg == TILE_CLAMP);

    always_comb begin
        inc_x = clamp ? (step_x_reg >>> 1) : step_x_reg;
        inc_y = clamp ? (step_y_reg >>> 1) : step_y_reg;
        if (s_data.new_span) begin
            pos_x_next  = clamp ? (s_data.start_x >>> 1) : s_data.start_x;
            pos_y_next  = clamp ? (s_data.start_y >>> 1) : s_data.start_y;
            dither_next = s_data.dither_phase;
        end else begin
            pos_x_next  = pos_x_reg + inc_x;
            pos_y_next  = pos_y_reg + inc_y;
            dither_next = !dither_reg;
        end
        push_entry.pos_x  = pos_x_next;
        push_entry.pos_y  = pos_y_next;
        push_entry.dither = dither_next;
        push_entry.clamp  = clamp;
        push_entry.mirror = (tile_mode_reg == TILE_MIRROR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_mode_reg <= TILE_CLAMP;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            dither_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index_t'(cfg_index))
                    CFG_TILE_MODE: tile_mode_reg <= tile_mode_t'(cfg_data[1:0]);
                    CFG_STEP_X:    step_x_reg    <= cfg_data;
                    CFG_STEP_Y:    step_y_reg    <= cfg_data;
                    default:       ;
                endcase
            end
            if (push) begin
                pos_x_reg  <= pos_x_next;
                pos_y_reg  <= pos_y_next;
                dither_reg <= dither_next;
            end
        end
    end

endmodule

### sv/rgig_queue.sv
// Two-entry queue of positions between the front and back ends.
// Depends on rgig_pkg.
module rgig_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rgig_pkg::q_entry_t push_entry,
    input  logic               pop,
    output logic               q_valid,
    output logic               q_full,
    output rgig_pkg::q_entry_t head
);
    import rgig_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    q_entry_t        slot [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign head    = slot[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### sv/rgig_back.sv
// Back end: table fill, shared squarer, square-root unit, ROM read, result register.
// Depends on rgig_pkg and rgig_ram.
module rgig_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  rgig_pkg::q_entry_t  head,
    output logic                pop,
    output logic                fill_done,
    output logic                m_valid,
    input  logic                m_ready,
    output rgig_pkg::out_item_t m_data
);
    import rgig_pkg::*;

    back_state_t state_reg, state_next;

    // work item
    logic signed [31:0] x_reg, y_reg;
    logic               dither_reg, clamp_reg, mirror_reg;
    // squarer
    logic [31:0] mul_op;
    logic [63:0] prod_reg;
    logic [31:0] term, acc_reg, sum;
    // square root
    logic [47:0] sq_n_reg;
    logic [26:0] rem_reg, rem_sh, trial;
    logic [23:0] root_reg;
    logic [4:0]  sq_cnt_reg;
    logic [31:0] m_sat;
    // table fill
    logic [ROM_AW:0] fill_idx_reg;
    logic [8:0]      fill_root_reg;
    logic [16:0]     fill_sq_reg;
    logic [16:0]     fill_v;
    logic            fill_adv;
    // ROM
    logic [31:0]       fi_wide;
    logic [ROM_AW-1:0] rom_raddr;
    logic [7:0]        rom_rdata;
    logic              ram_we;
    // result
    logic [7:0]  idx_reg;
    logic [15:0] tile_fi;
    logic        load_out;
    logic        out_valid_reg;
    out_item_t   out_reg;

    function automatic logic [31:0] mag_pinned(input logic signed [31:0] s);
        logic [31:0] r;
        if (s[31]) begin
            r = (s < -$signed(PIN_LIMIT)) ? PIN_LIMIT : 32'(-s);
        end else begin
            r = (s > $signed(PIN_LIMIT)) ? PIN_LIMIT : 32'(s);
        end
        return r;
    endfunction

    function automatic logic [31:0] mag_full(input logic signed [31:0] s);
        return s[31] ? (~32'(s) + 32'd1) : 32'(s);
    endfunction

    rgig_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_idx_reg[ROM_AW-1:0]),
        .wdata (fill_root_reg[7:0]),
        .raddr (rom_raddr),
        .rdata (rom_rdata)
    );

    // datapath helpers
    always_comb begin
        if (state_reg == BK_MUL_X) begin
            mul_op = clamp_reg ? mag_pinned(x_reg) : mag_full(x_reg);
        end else begin
            mul_op = clamp_reg ? mag_pinned(y_reg) : mag_full(y_reg);
        end
        term    = clamp_reg ? prod_reg[31:0] : prod_reg[47:16];
        sum     = acc_reg + term;
        m_sat   = sum[31] ? 32'h7FFF_FFFF : sum;
        rem_sh  = {rem_reg[24:0], sq_n_reg[47:46]};
        trial   = {1'b0, root_reg, 2'b01};
        fi_wide = acc_reg >> CLAMP_SHIFT;
        rom_raddr = (fi_wide > 32'(ROM_DEPTH-1)) ? ROM_AW'(ROM_DEPTH-1) : fi_wide[ROM_AW-1:0];
        fill_v  = 17'(fill_idx_reg[ROM_AW-1:0]) << FILL_SHIFT;
        fill_adv = (fill_sq_reg <= fill_v);
        tile_fi = root_reg[15:0] ^ {16{mirror_reg && root_reg[16]}};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_FILL:     if (!fill_adv && fill_idx_reg[ROM_AW-1:0] == ROM_AW'(ROM_DEPTH-1)) begin
                             state_next = BK_IDLE;
                         end
            BK_IDLE:     if (q_valid) state_next = BK_MUL_X;
            BK_MUL_X:    state_next = BK_MUL_Y;
            BK_MUL_Y:    state_next = BK_SUM;
            BK_SUM:      state_next = clamp_reg ? BK_ROM_RD : BK_SQRT;
            BK_ROM_RD:   state_next = BK_ROM_WAIT;
            BK_ROM_WAIT: state_next = BK_DONE;
            BK_SQRT:     if (sq_cnt_reg == 5'(SQRT_STEPS-1)) state_next = BK_DONE;
            BK_DONE:     if (!out_valid_reg || m_ready) state_next = BK_IDLE;
            default:     state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop       = 1'b0;
        ram_we    = 1'b0;
        load_out  = 1'b0;
        fill_done = 1'b1;
        unique case (state_reg)
            BK_FILL: begin
                fill_done = 1'b0;
                ram_we    = !fill_adv;
            end
            BK_IDLE: pop      = q_valid;
            BK_DONE: load_out = !out_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_FILL;
            fill_idx_reg  <= '0;
            fill_root_reg <= '0;
            fill_sq_reg   <= 17'd1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_FILL) begin
                if (fill_adv) begin
                    fill_sq_reg   <= fill_sq_reg + {7'd0, fill_root_reg, 1'b0} + 17'd3;
                    fill_root_reg <= fill_root_reg + 9'd1;
                end else begin
                    fill_idx_reg <= fill_idx_reg + 1'b1;
                end
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            x_reg      <= head.pos_x;
            y_reg      <= head.pos_y;
            dither_reg <= head.dither;
            clamp_reg  <= head.clamp;
            mirror_reg <= head.mirror;
        end
        if (state_reg == BK_MUL_X || state_reg == BK_MUL_Y) begin
            prod_reg <= mul_op * mul_op;
        end
        if (state_reg == BK_MUL_Y) begin
            acc_reg <= term;
        end
        if (state_reg == BK_SUM) begin
            acc_reg    <= sum;
            sq_n_reg   <= {1'b0, m_sat[30:0], 16'd0};
            rem_reg    <= '0;
            root_reg   <= '0;
            sq_cnt_reg <= '0;
        end
        if (state_reg == BK_SQRT) begin
            sq_n_reg   <= {sq_n_reg[45:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg + 5'd1;
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[22:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[22:0], 1'b0};
            end
        end
        if (state_reg == BK_ROM_WAIT) begin
            idx_reg <= 8'(rom_rdata >> (8 - CACHE_BITS));
        end
        if (load_out) begin
            out_reg.color_index <= clamp_reg ? idx_reg : 8'(tile_fi >> (16 - CACHE_BITS));
            out_reg.dither_row  <= dither_reg;
        end
    end

    // the root holds its final value throughout DONE
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### sv/radial_gradient_index_gen.sv
// Top level of the radial gradient index generator.
// Depends on rgig_pkg, rgig_front, rgig_queue, rgig_back (and rgig_ram below it).
//
// One input transaction yields one result transaction: a gradient color-cache
// index and a dither row bit. After reset the block fills its square-root
// table (2048 entries, 255 square-root increments); s_ready stays low
// meanwhile, configuration writes are taken throughout. The front end
// updates the position at once and queues it (two entries), so the input
// side can accept while the back end works. The back end handles one pixel
// at a time with a single shared 32x32 squarer: clamp mode goes through two
// squares, sum and table read; repeat, mirror and the unused mode code go
// through two squares, sum and a 24-step bit-serial square root.
// Configuration is written by cfg_index 0 (tile_mode), 1 (step_x),
// 2 (step_y); writes are accepted every cycle and must come while idle.
module radial_gradient_index_gen (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rgig_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rgig_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import rgig_pkg::*;

    logic     push, pop, q_valid, q_full, fill_done;
    q_entry_t push_entry, head;

    // always take register writes
    assign cfg_ready = 1'b1;

    rgig_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .fill_done  (fill_done),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouple position update from the distance computation
    rgig_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .head       (head)
    );

    rgig_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .fill_done (fill_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### sv/rgig_checker.sv
// Port-level checks for radial_gradient_index_gen, attached by bind.
// Depends on rgig_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rgig_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rgig_pkg::out_item_t m_data,
    input logic                cfg_valid,
    input logic                cfg_ready
);
    import rgig_pkg::*;

    `ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")
    `ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid && !s_ready, "not quiet after reset")
    `ASSERT_RST(a_cfg_taken, aclk, aresetn, cfg_valid |-> cfg_ready, "config write refused")

endmodule

bind radial_gradient_index_gen rgig_checker u_rgig_checker (.*);

### tb/sv/tb_top.sv
// Self-checking testbench for radial_gradient_index_gen: drives pixel transactions,
// predicts each color index and dither bit, and checks them in order.
// Depends on rgig_pkg and the RTL of radial_gradient_index_gen.

class gradient_scoreboard;
    // Predicted state and configuration.
    bit [31:0] acc_x, acc_y;
    bit        dith;
    bit [1:0]  mode;
    bit [31:0] stp_x, stp_y;
    bit [7:0]  root_rom [0:2047];
    rgig_pkg::out_item_t pending[$];
    int errors;
    int checked;

    function new();
        for (int i = 0; i < 2048; i++)
            root_rom[i] = 8'(fsqrt(32'(i) << 5) >> 8);
        acc_x = 0; acc_y = 0; dith = 0; mode = 0; stp_x = 0; stp_y = 0;
        errors = 0; checked = 0;
    endfunction

    function bit [63:0] isqrt(bit [63:0] n);
        bit [63:0] root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function bit [31:0] fsqrt(bit [31:0] m);
        return 32'(isqrt({16'd0, m, 16'd0}));
    endfunction

    function bit [31:0] halve(bit [31:0] v);
        return {v[31], v[31:1]};
    endfunction

    function bit [31:0] fsquare(bit [31:0] v);
        longint s;
        bit [63:0] a;
        s = longint'($signed(v));
        a = (s < 0) ? -s : s;
        return 32'((a * a) >> 16);
    endfunction

    function bit [63:0] pinsq(bit [31:0] v);
        longint s;
        s = longint'($signed(v));
        if (s > 32767) s = 32767;
        if (s < -32767) s = -32767;
        return s * s;
    endfunction

    function void write_reg(rgig_pkg::cfg_index_t idx, bit [31:0] val);
        case (idx)
            rgig_pkg::CFG_TILE_MODE: mode = val[1:0];
            rgig_pkg::CFG_STEP_X:    stp_x = val;
            rgig_pkg::CFG_STEP_Y:    stp_y = val;
            default: ;
        endcase
    endfunction

    // Note an accepted pixel: advance position and queue its expected result.
    function void note_pixel(rgig_pkg::in_item_t it);
        bit clamp;
        bit [63:0] sum;
        bit [31:0] m, root_v, fi;
        rgig_pkg::out_item_t r;
        clamp = (mode == rgig_pkg::TILE_CLAMP);
        if (it.new_span) begin
            acc_x = clamp ? halve(it.start_x) : it.start_x;
            acc_y = clamp ? halve(it.start_y) : it.start_y;
            dith = it.dither_phase;
        end else begin
            acc_x += clamp ? halve(stp_x) : stp_x;
            acc_y += clamp ? halve(stp_y) : stp_y;
            dith ^= 1'b1;
        end
        if (clamp) begin
            sum = (pinsq(acc_x) + pinsq(acc_y)) >> 19;
            if (sum > 2047) sum = 2047;
            r.color_index = root_rom[sum[10:0]];
        end else begin
            m = fsquare(acc_x) + fsquare(acc_y);
            if (m[31]) m = 32'h7FFF_FFFF;
            root_v = fsqrt(m);
            fi = root_v & 32'hFFFF;
            if (mode == rgig_pkg::TILE_MIRROR && root_v[16]) fi ^= 32'hFFFF;
            r.color_index = fi[15:8];
        end
        r.dither_row = dith;
        pending.push_back(r);
    endfunction

    function void check_pixel(rgig_pkg::out_item_t got);
        rgig_pkg::out_item_t exp_r;
        checked++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result idx=%0d row=%0b", $time,
                     got.color_index, got.dither_row);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.color_index !== exp_r.color_index) begin
            $display("%0t: color_index expected %0d actual %0d", $time,
                     exp_r.color_index, got.color_index);
            errors++;
        end
        if (got.dither_row !== exp_r.dither_row) begin
            $display("%0t: dither_row expected %0b actual %0b", $time,
                     exp_r.dither_row, got.dither_row);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rgig_pkg::*;

    logic      aclk, aresetn;
    logic      s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    in_item_t  s_data;
    out_item_t m_data;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    radial_gradient_index_gen dut (.*);

    gradient_scoreboard sb = new();

    // Idle chances out of a hundred, per side; changed between phases.
    int src_idle = 0;
    int snk_stall = 0;
    bit hold_off = 0;
    int accepted = 0;
    int idle_cycles = 0;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: random stalls, or a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_off && ($urandom_range(99) >= snk_stall);
        end
    end

    // Check every result transaction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pixel(m_data);
    end

    // Watchdog: count cycles without any transaction; the fill pass is covered.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Watchdog expired");
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_cfg(cfg_index_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // Offer one pixel transaction; hold it until accepted. Valid stays high
    // afterwards unless the sender idles or drain drops it.
    task automatic send_pixel(logic ns, logic [31:0] x, logic [31:0] y, logic ph);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{new_span: ns, start_x: x, start_y: y, dither_phase: ph};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_pixel(s_data);
        accepted++;
    endtask

    // Drain: drop valid, wait until every expected result is back, then settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
            2: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
            3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000);
        endcase
    endfunction

    task automatic random_spans(int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            send_pixel(1'b1, rnd_coord(), rnd_coord(), 1'($urandom()));
            sent++;
            repeat ($urandom_range(12)) begin
                send_pixel(1'b0, $urandom(), $urandom(), 1'($urandom()));
                sent++;
            end
        end
    endtask

    initial begin
        logic [31:0] modes [4];
        aresetn = 0; s_valid = 0; s_data = '0; cfg_valid = 0;
        cfg_index = CFG_NONE; cfg_data = '0; m_ready = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Step before any span, from the reset position and mode.
        send_pixel(1'b0, '0, '0, 1'b0);
        send_pixel(1'b0, '1, '1, 1'b1);
        drain();

        // Directed: field extremes in every mode, including the unused code.
        modes = '{TILE_CLAMP, TILE_REPEAT, TILE_MIRROR, TILE_RSVD};
        foreach (modes[m]) begin
            write_cfg(CFG_TILE_MODE, modes[m]);
            write_cfg(CFG_STEP_X, 32'h0001_0000);
            write_cfg(CFG_STEP_Y, 32'hFFFF_8000);
            send_pixel(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
            send_pixel(1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0);
            send_pixel(1'b1, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b1);
            send_pixel(1'b0, '0, '0, 1'b0);
            send_pixel(1'b1, 32'h0000_B505, 32'h0000_B504, 1'b0);
            drain();
        end
        // Mode change inside a span: held position carries over unscaled.
        write_cfg(CFG_TILE_MODE, TILE_CLAMP);
        send_pixel(1'b1, 32'h0003_0000, 32'hFFFD_0000, 1'b0);
        drain();
        write_cfg(CFG_TILE_MODE, TILE_MIRROR);
        send_pixel(1'b0, '0, '0, 1'b0);
        send_pixel(1'b0, '0, '0, 1'b0);
        drain();

        // Random phases; steps move across extremes and random values.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 71; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 71; end
                default: begin src_idle = 22; snk_stall = 22; end
            endcase
            write_cfg(CFG_TILE_MODE, 32'($urandom_range(3)));
            write_cfg(CFG_STEP_X, ph == 0 ? 32'h7FFF_FFFF : ph == 1 ? 32'h8000_0000
                                  : 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000));
            write_cfg(CFG_STEP_Y, ph == 0 ? 32'h8000_0000 : ph == 1 ? 32'h7FFF_FFFF
                                  : $urandom());
            random_spans(70);
            drain();
        end

        // Receiver holds off for a long stretch while the sender keeps offering.
        src_idle = 0; snk_stall = 0;
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            random_spans(20);
        join
        drain();

        $display("Sent %0d pixel transactions over clamp, repeat, mirror and the", accepted);
        $display("unused mode code, with stalls on both sides; %0d results checked", sb.checked);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
